FILE: src/xoroshiro128plus_generator_assert.svh
// Assertion macros used by the generator RTL.
`ifndef XOROSHIRO128PLUS_GENERATOR_ASSERT_SVH
`define XOROSHIRO128PLUS_GENERATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define XR128_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define XR128_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define XR128_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define XR128_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/xr128_pkg.sv
// Types and constants shared by the xoroshiro128+ generator modules.
package xr128_pkg;

    localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

    localparam int ROT_A      = 55;
    localparam int SHL_B      = 14;
    localparam int ROT_C      = 36;
    localparam int MIX_SHR_A  = 30;
    localparam int MIX_SHR_B  = 27;
    localparam int MIX_SHR_C  = 31;
    localparam int FRAC_SHIFT = 11;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [6:0] count;
    } t_in_req;

    typedef struct packed {
        logic [63:0] value;
        logic [52:0] fraction;
        logic        last;
    } t_out_res;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INC,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_XOR27,
        OP_FIN,
        OP_STEP
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   k_sel;     // 0 selects the first mix multiplier, 1 the second
        logic   word_sel;  // 0 writes word A, 1 writes word B
        logic   last;
    } t_dp_cmd;

endpackage

FILE: src/xr128_datapath.sv
// Datapath: state words, splitmix64 seeding unit and output register.
module xr128_datapath
    import xr128_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    output t_out_res    o_out_data
);

    logic [63:0] r_seed;
    logic [63:0] r_acc;
    logic [63:0] r_z;
    logic [63:0] r_prod;
    logic [63:0] r_wa;
    logic [63:0] r_wb;
    t_out_res    r_out;

    logic [63:0] n_acc;
    logic [63:0] mul_k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] mix_fin;
    logic [63:0] sum;
    logic [63:0] x;
    logic [63:0] n_wa;
    logic [63:0] n_wb;

    assign n_acc = r_acc + GOLDEN_INC;
    assign mul_k = i_cmd.k_sel ? MIX_MUL_B : MIX_MUL_A;

    // The low 64 bits of the 64x64 product come from three 32x32 products;
    // the two cross terms only contribute their low halves.
    assign mul_a = (i_cmd.op == OP_MUL1) ? r_z[63:32] : r_z[31:0];
    assign mul_b = (i_cmd.op == OP_MUL2) ? mul_k[63:32] : mul_k[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign mix_fin = r_prod ^ (r_prod >> MIX_SHR_C);

    assign sum  = r_wa + r_wb;
    assign x    = r_wa ^ r_wb;
    assign n_wa = ((r_wa << ROT_A) | (r_wa >> (64 - ROT_A))) ^ x ^ (x << SHL_B);
    assign n_wb = (x << ROT_C) | (x >> (64 - ROT_C));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_data;
        end
    end

    // The accumulator resets to zero so the startup seeding pass expands seed 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.op == OP_LOAD) begin
            r_acc <= r_seed;
        end else if (i_cmd.op == OP_INC) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_INC: begin
                r_z <= n_acc ^ (n_acc >> MIX_SHR_A);
            end
            OP_MUL0: begin
                r_prod <= mul_p;
            end
            OP_MUL1, OP_MUL2: begin
                r_prod <= r_prod + {mul_p[31:0], 32'b0};
            end
            OP_XOR27: begin
                r_z <= r_prod ^ (r_prod >> MIX_SHR_B);
            end
            OP_FIN: begin
                if (i_cmd.word_sel) begin
                    r_wb <= mix_fin;
                end else begin
                    r_wa <= mix_fin;
                end
            end
            OP_STEP: begin
                r_wa           <= n_wa;
                r_wb           <= n_wb;
                r_out.value    <= sum;
                r_out.fraction <= sum[63:FRAC_SHIFT];
                r_out.last     <= i_cmd.last;
            end
            default: begin
            end
        endcase
    end

    assign o_out_data = r_out;

endmodule

FILE: src/xr128_ctrl.sv
// Controller: request acceptance, seeding sequence and draw counting.
`include "xoroshiro128plus_generator_assert.svh"
module xr128_ctrl
    import xr128_pkg::*;
#(
    parameter int MAX_DRAW = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_in_req i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    localparam int LW = $clog2(MAX_DRAW + 1);
    localparam logic [6:0] MAX_COUNT = 7'(MAX_DRAW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_INC,
        S_MA0,
        S_MA1,
        S_MA2,
        S_XOR,
        S_MB0,
        S_MB1,
        S_MB2,
        S_FIN,
        S_DRAW
    } t_state;

    t_state      r_state;
    logic        r_second;
    logic [LW-1:0] r_left;
    logic        r_out_valid;

    logic        in_accept;
    logic        step;
    logic [6:0]  sat_count;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign step        = (r_state == S_DRAW) && (!r_out_valid || !i_out_stall);
    assign sat_count   = (i_in_data.count > MAX_COUNT) ? MAX_COUNT : i_in_data.count;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.word_sel = r_second;
        o_cmd.last     = (r_left == LW'(1));
        case (r_state)
            S_LOAD:  o_cmd.op = OP_LOAD;
            S_INC:   o_cmd.op = OP_INC;
            S_MA0:   o_cmd.op = OP_MUL0;
            S_MA1:   o_cmd.op = OP_MUL1;
            S_MA2:   o_cmd.op = OP_MUL2;
            S_XOR:   o_cmd.op = OP_XOR27;
            S_MB0: begin
                o_cmd.op    = OP_MUL0;
                o_cmd.k_sel = 1'b1;
            end
            S_MB1: begin
                o_cmd.op    = OP_MUL1;
                o_cmd.k_sel = 1'b1;
            end
            S_MB2: begin
                o_cmd.op    = OP_MUL2;
                o_cmd.k_sel = 1'b1;
            end
            S_FIN:   o_cmd.op = OP_FIN;
            S_DRAW:  o_cmd.op = step ? OP_STEP : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset runs the seeding pass from an accumulator of zero.
            r_state     <= S_INC;
            r_second    <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_in_data.cmd == CMD_RESEED) begin
                            r_state <= S_LOAD;
                        end else if (sat_count != 7'd0) begin
                            r_left  <= LW'(sat_count);
                            r_state <= S_DRAW;
                        end
                    end
                end
                S_LOAD: begin
                    r_second <= 1'b0;
                    r_state  <= S_INC;
                end
                S_INC:  r_state <= S_MA0;
                S_MA0:  r_state <= S_MA1;
                S_MA1:  r_state <= S_MA2;
                S_MA2:  r_state <= S_XOR;
                S_XOR:  r_state <= S_MB0;
                S_MB0:  r_state <= S_MB1;
                S_MB1:  r_state <= S_MB2;
                S_MB2:  r_state <= S_FIN;
                S_FIN: begin
                    r_second <= !r_second;
                    r_state  <= r_second ? S_IDLE : S_INC;
                end
                S_DRAW: begin
                    if (step) begin
                        r_left <= r_left - LW'(1);
                        if (r_left == LW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `XR128_ASSERT_NOW(a_draw_has_work, i_clk, i_rst_n, r_state == S_DRAW, r_left != '0)
    `XR128_ASSERT_NOW(a_left_bounded, i_clk, i_rst_n, 1'b1, r_left <= LW'(MAX_DRAW))
    `XR128_ASSERT_NEXT(a_reseed_loads, i_clk, i_rst_n, in_accept && (i_in_data.cmd == CMD_RESEED), r_state == S_LOAD)
    `XR128_ASSERT_NEXT(a_step_sets_valid, i_clk, i_rst_n, step, o_out_valid)

endmodule

FILE: src/xoroshiro128plus_generator.sv
// Top level of the xoroshiro128+ generator with splitmix64 seeding.
// A draw request of count values (saturated to MAX_DRAW, zero gives nothing) is accepted
// in the idle state and then delivers one result per cycle while the output is not
// stalled; the rate is set by the state update feeding the output register. A reseed
// request is accepted, loads the seed and then runs two splitmix64 rounds, each an
// increment, three multiply steps, an xor-shift, three more multiply steps and a final
// mix, paced by the shared 32x32 multiplier that forms each 64-bit product in three steps.
// After reset the same seeding pass runs from seed 0, and requests stall until it ends.
// The seed register can be written at any time and takes effect on the next reseed.
module xoroshiro128plus_generator
    import xr128_pkg::*;
#(
    parameter int MAX_DRAW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_res    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    t_dp_cmd dp_cmd;

    assign o_cfg_ready = 1'b1;

    xr128_ctrl #(
        .MAX_DRAW(MAX_DRAW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    xr128_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

endmodule
